[hw/rtl/assert_macros.svh]
// Assertion macros for the ray caster RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define DGRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true out of reset.
`define DGRC_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

[hw/rtl/dgrc_pkg.sv]
// Types and constants of the grid ray caster.
`default_nettype none

package dgrc_pkg;

    // Fixed point formats.
    localparam int FRAC_BITS = 8;
    localparam int DIR_FRAC  = 14;

    // Field and internal widths.
    localparam int POS_W   = 20;
    localparam int TILE_W  = 9;
    localparam int DIM_W   = 7;
    localparam int DIR_W   = 16;
    localparam int MAG_W   = 16;
    localparam int CXY_W   = 6;
    localparam int VAL_W   = 8;
    localparam int HIT_W   = 22;
    localparam int NUM_W   = 22;
    localparam int CELL_W  = 16;
    localparam int DIVD_W  = 36;
    localparam int CNT_W   = 6;
    localparam int DM_W    = 36;
    localparam int CMP_W   = 38;
    localparam int HD_W    = 37;
    localparam int LO_W    = 20;
    localparam int PROD_W  = 36;
    localparam int ACC_W   = 53;
    localparam int OFF_W   = 39;
    localparam int SUM_W   = 42;
    localparam int TPIX_W  = TILE_W + FRAC_BITS;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEPTH  = 2'd3;

    // Register reset values and the largest tile size.
    localparam logic [TILE_W-1:0] TILE_RST  = 9'd64;
    localparam logic [DIM_W-1:0]  DIM_RST   = 7'd64;
    localparam logic [POS_W-1:0]  DEPTH_RST = 20'd262144;
    localparam logic [TILE_W-1:0] TILE_MAX  = 9'd256;

    // Operation codes of an input word.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Divider operand selection.
    localparam logic [1:0] DSEL_TX   = 2'd0;
    localparam logic [1:0] DSEL_TY   = 2'd1;
    localparam logic [1:0] DSEL_DIST = 2'd2;

    // Hit point multiply sequence.
    localparam logic [2:0] MS_XLO  = 3'd0;
    localparam logic [2:0] MS_XHI  = 3'd1;
    localparam logic [2:0] MS_YLO  = 3'd2;
    localparam logic [2:0] MS_YHI  = 3'd3;
    localparam logic [2:0] MS_LAST = 3'd4;

    // Distance bias of 0.07 pixel, rounded.
    localparam logic [HD_W-1:0] BIAS_Q = HD_W'(((7 << FRAC_BITS) + 50) / 100);
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Saturation limits of the hit point.
    localparam logic signed [SUM_W-1:0] HIT_HI = 42'sd2097151;
    localparam logic signed [SUM_W-1:0] HIT_LO = -42'sd2097152;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       capture;
        logic       write;
        logic       div_start;
        logic [1:0] div_sel;
        logic       lat_x;
        logic       lat_y;
        logic       init;
        logic       step;
        logic       rd;
        logic       test;
        logic       lat_dist;
        logic       mul_en;
        logic [2:0] mul_step;
        logic       out_load;
    } dgrc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
        logic depth_zero;
        logic stop;
        logic out_free;
    } dgrc_sts_t;

endpackage

`default_nettype wire

[hw/rtl/dgrc_in_if.sv]
// Input channel of the ray caster: write and cast words.
`default_nettype none

interface dgrc_in_if;
    import dgrc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [CXY_W-1:0]        cell_x;
    logic [CXY_W-1:0]        cell_y;
    logic [VAL_W-1:0]        cell_value;
    logic [POS_W-1:0]        origin_x;
    logic [POS_W-1:0]        origin_y;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;

    modport source (
        output valid, op, cell_x, cell_y, cell_value, origin_x, origin_y, dir_x, dir_y,
        input  ready
    );
    modport sink (
        input  valid, op, cell_x, cell_y, cell_value, origin_x, origin_y, dir_x, dir_y,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/dgrc_out_if.sv]
// Output channel of the ray caster: one result word per cast.
`default_nettype none

interface dgrc_out_if;
    import dgrc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    hit_found;
    logic [VAL_W-1:0]        wall_type;
    logic [POS_W-1:0]        hit_distance;
    logic [POS_W-1:0]        perp_distance;
    logic signed [HIT_W-1:0] hit_x;
    logic signed [HIT_W-1:0] hit_y;
    logic                    side;

    modport source (
        output valid, hit_found, wall_type, hit_distance, perp_distance, hit_x, hit_y, side,
        input  ready
    );
    modport sink (
        input  valid, hit_found, wall_type, hit_distance, perp_distance, hit_x, hit_y, side,
        output ready
    );
endinterface

`default_nettype wire

[hw/rtl/dgrc_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module dgrc_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [dgrc_pkg::DIVD_W-1:0] dividend,
    input  wire logic [dgrc_pkg::MAG_W-1:0]  divisor,
    output logic                            busy,
    output logic [dgrc_pkg::DIVD_W-1:0]     quotient,
    output logic [dgrc_pkg::MAG_W-1:0]      remainder
);
    import dgrc_pkg::*;

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [MAG_W-1:0]  rem_reg;
    logic [MAG_W-1:0]  dvs_reg;
    logic [MAG_W:0]    trial;
    logic              qbit;

    // Shift in the next dividend bit and try to subtract.
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIVD_W-1]};
        qbit  = (trial >= {1'b0, dvs_reg});
    end

    // Control: count the iterations.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVD_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Quotient and partial remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-2:0], qbit};
            rem_reg <= qbit ? MAG_W'(trial - {1'b0, dvs_reg}) : trial[MAG_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[hw/rtl/dgrc_dpath.sv]
// Datapath of the ray caster: map memory, grid walk, distances, result register.
`default_nettype none

module dgrc_dpath #(
    parameter int MAP_W_MAX = 64,
    parameter int MAP_H_MAX = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dgrc_pkg::dgrc_cmd_t               cmd,
    output dgrc_pkg::dgrc_sts_t                    sts,
    input  wire logic                              cfg_we,
    input  wire logic [dgrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dgrc_pkg::POS_W-1:0]        cfg_data,
    input  wire logic [dgrc_pkg::CXY_W-1:0]        in_cell_x,
    input  wire logic [dgrc_pkg::CXY_W-1:0]        in_cell_y,
    input  wire logic [dgrc_pkg::VAL_W-1:0]        in_cell_value,
    input  wire logic [dgrc_pkg::POS_W-1:0]        in_origin_x,
    input  wire logic [dgrc_pkg::POS_W-1:0]        in_origin_y,
    input  wire logic signed [dgrc_pkg::DIR_W-1:0] in_dir_x,
    input  wire logic signed [dgrc_pkg::DIR_W-1:0] in_dir_y,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic                                   out_hit_found,
    output logic [dgrc_pkg::VAL_W-1:0]             out_wall_type,
    output logic [dgrc_pkg::POS_W-1:0]             out_hit_distance,
    output logic [dgrc_pkg::POS_W-1:0]             out_perp_distance,
    output logic signed [dgrc_pkg::HIT_W-1:0]      out_hit_x,
    output logic signed [dgrc_pkg::HIT_W-1:0]      out_hit_y,
    output logic                                   out_side
);
    import dgrc_pkg::*;

    localparam int DEPTH  = MAP_W_MAX * MAP_H_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers.
    logic [TILE_W-1:0] tile_reg;
    logic [DIM_W-1:0]  mapw_reg;
    logic [DIM_W-1:0]  maph_reg;
    logic [POS_W-1:0]  depth_reg;

    // Ray registers.
    logic [POS_W-1:0]  ox_reg, oy_reg;
    logic              xneg_reg, yneg_reg;
    logic [MAG_W-1:0]  adx_reg, ady_reg;
    logic [CELL_W-1:0] cx_reg, cy_reg;
    logic [NUM_W-1:0]  numx_reg, numy_reg;
    logic [NUM_W-1:0]  lnum_reg;
    logic [MAG_W-1:0]  lmag_reg;
    logic [DM_W-1:0]   dmx_reg, dmy_reg;
    logic [DIVD_W-1:0] dist_reg;
    logic              side_reg, stepped_reg, hit_reg;
    logic [VAL_W-1:0]  wall_reg, rd_reg;
    logic [PROD_W-1:0] prod_reg, acclo_reg;
    logic [ACC_W-1:0]  offx_reg, offy_reg;

    // Result register.
    logic              ovalid_reg;
    logic              ohit_reg, oside_reg;
    logic [VAL_W-1:0]  owall_reg;
    logic [POS_W-1:0]  ohd_reg, operp_reg;
    logic [HIT_W-1:0]  ohx_reg, ohy_reg;

    logic [VAL_W-1:0]  mem [DEPTH];

    logic [TILE_W-1:0] tile_eff;
    logic [TPIX_W-1:0] tpix;
    logic [TILE_W-1:0] mw_eff, mh_eff;
    logic              inb;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              wr_ok;
    logic [DIVD_W-1:0] div_dvd, div_q;
    logic [MAG_W-1:0]  div_dvs, div_r;
    logic              div_busy;
    logic [FRAC_BITS+VAL_W-1:0] rem_pix;
    logic [CMP_W-1:0]  px, py;
    logic              takex;
    logic [DM_W-1:0]   dm_last;
    logic              dstop, cell_hit, inf;
    logic [HD_W-1:0]   hd;
    logic [MAG_W-1:0]  mul_a;
    logic [LO_W-1:0]   mul_b;
    logic              out_free;

    // Clamp of a hit coordinate to the signed output range.
    function automatic logic [HIT_W-1:0] sat_coord(
        input logic [POS_W-1:0] org,
        input logic             neg,
        input logic [OFF_W-1:0] off
    );
        logic signed [SUM_W-1:0] s;
        s = neg ? $signed(SUM_W'(org)) - $signed(SUM_W'(off))
                : $signed(SUM_W'(org)) + $signed(SUM_W'(off));
        if (s > HIT_HI)
            return HIT_HI[HIT_W-1:0];
        else if (s < HIT_LO)
            return HIT_LO[HIT_W-1:0];
        else
            return s[HIT_W-1:0];
    endfunction

    // The y tile division follows the x one; the select tells which origin is in use.
    function automatic logic div_sel_y();
        return cmd.lat_y;
    endfunction

    // Effective register values.
    always_comb
    begin
        if (tile_reg == '0)
            tile_eff = TILE_W'(1);
        else if (tile_reg > TILE_MAX)
            tile_eff = TILE_MAX;
        else
            tile_eff = tile_reg;
        tpix   = {tile_eff, {FRAC_BITS{1'b0}}};
        mw_eff = (int'(mapw_reg) > MAP_W_MAX) ? TILE_W'(MAP_W_MAX) : TILE_W'(mapw_reg);
        mh_eff = (int'(maph_reg) > MAP_H_MAX) ? TILE_W'(MAP_H_MAX) : TILE_W'(maph_reg);
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_reg  <= TILE_RST;
            mapw_reg  <= DIM_RST;
            maph_reg  <= DIM_RST;
            depth_reg <= DEPTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TILE_SIZE:  tile_reg  <= cfg_data[TILE_W-1:0];
                CFG_MAP_WIDTH:  mapw_reg  <= cfg_data[DIM_W-1:0];
                CFG_MAP_HEIGHT: maph_reg  <= cfg_data[DIM_W-1:0];
                CFG_MAX_DEPTH:  depth_reg <= cfg_data;
                default:        tile_reg  <= tile_reg;
            endcase
        end
    end

    // Map memory: one write port from the input, one registered read port for the walk.
    always_comb
    begin
        inb = !cx_reg[CELL_W-1] && !cy_reg[CELL_W-1]
              && (cx_reg[CELL_W-2:0] < (CELL_W-1)'(mw_eff))
              && (cy_reg[CELL_W-2:0] < (CELL_W-1)'(mh_eff));
        rd_addr = ADDR_W'(int'(cy_reg[CELL_W-2:0]) * MAP_W_MAX + int'(cx_reg[CELL_W-2:0]));
        wr_ok   = (int'(in_cell_x) < MAP_W_MAX) && (int'(in_cell_y) < MAP_H_MAX);
        wr_addr = ADDR_W'(int'(in_cell_y) * MAP_W_MAX + int'(in_cell_x));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_ok)
            mem[wr_addr] <= in_cell_value;
        if (cmd.rd)
            rd_reg <= mem[rd_addr];
    end

    // Shared divider: tile index of each origin, then the final crossing distance.
    always_comb
    begin
        unique case (cmd.div_sel)
            DSEL_TX:
            begin
                div_dvd = DIVD_W'(ox_reg[POS_W-1:FRAC_BITS]);
                div_dvs = MAG_W'(tile_eff);
            end
            DSEL_TY:
            begin
                div_dvd = DIVD_W'(oy_reg[POS_W-1:FRAC_BITS]);
                div_dvs = MAG_W'(tile_eff);
            end
            default:
            begin
                div_dvd = {lnum_reg, {DIR_FRAC{1'b0}}};
                div_dvs = lmag_reg;
            end
        endcase
    end

    dgrc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Step choice, depth check and hit test.
    always_comb
    begin
        rem_pix = {div_r[VAL_W-1:0], (div_sel_y() ? oy_reg[FRAC_BITS-1:0]
                                                  : ox_reg[FRAC_BITS-1:0])};
        px = CMP_W'(numx_reg) * CMP_W'(ady_reg);
        py = CMP_W'(numy_reg) * CMP_W'(adx_reg);
        if (adx_reg == '0)
            takex = 1'b0;
        else if (ady_reg == '0)
            takex = 1'b1;
        else
            takex = (px < py);
        dm_last  = side_reg ? dmy_reg : dmx_reg;
        inf      = (lmag_reg == '0);
        dstop    = inf || ({lnum_reg, {DIR_FRAC{1'b0}}} >= dm_last);
        cell_hit = inb && (rd_reg != '0);
        hd       = HD_W'(dist_reg) + BIAS_Q;
        mul_a    = (cmd.mul_step == MS_XLO || cmd.mul_step == MS_XHI) ? adx_reg : ady_reg;
        mul_b    = (cmd.mul_step == MS_XLO || cmd.mul_step == MS_YLO) ? hd[LO_W-1:0]
                                                                      : LO_W'(hd[HD_W-1:LO_W]);
        out_free = !ovalid_reg || out_ready;
    end

    // Walk registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ox_reg   <= in_origin_x;
            oy_reg   <= in_origin_y;
            xneg_reg <= in_dir_x[DIR_W-1];
            yneg_reg <= in_dir_y[DIR_W-1];
            adx_reg  <= in_dir_x[DIR_W-1] ? MAG_W'(-$unsigned(in_dir_x)) : $unsigned(in_dir_x);
            ady_reg  <= in_dir_y[DIR_W-1] ? MAG_W'(-$unsigned(in_dir_y)) : $unsigned(in_dir_y);
        end
        if (cmd.lat_x)
        begin
            cx_reg   <= CELL_W'(div_q[POS_W-FRAC_BITS-1:0]);
            numx_reg <= xneg_reg ? NUM_W'(rem_pix) : NUM_W'(tpix) - NUM_W'(rem_pix);
        end
        if (cmd.lat_y)
        begin
            cy_reg   <= CELL_W'(div_q[POS_W-FRAC_BITS-1:0]);
            numy_reg <= yneg_reg ? NUM_W'(rem_pix) : NUM_W'(tpix) - NUM_W'(rem_pix);
        end
        if (cmd.init)
        begin
            dmx_reg     <= DM_W'(depth_reg) * DM_W'(adx_reg);
            dmy_reg     <= DM_W'(depth_reg) * DM_W'(ady_reg);
            dist_reg    <= '0;
            side_reg    <= 1'b0;
            stepped_reg <= 1'b0;
            hit_reg     <= 1'b0;
            wall_reg    <= '0;
            lmag_reg    <= MAG_W'(1);
        end
        if (cmd.step)
        begin
            stepped_reg <= 1'b1;
            if (takex)
            begin
                cx_reg   <= xneg_reg ? cx_reg - 1'b1 : cx_reg + 1'b1;
                lnum_reg <= numx_reg;
                lmag_reg <= adx_reg;
                numx_reg <= numx_reg + NUM_W'(tpix);
                side_reg <= 1'b0;
            end
            else
            begin
                cy_reg   <= yneg_reg ? cy_reg - 1'b1 : cy_reg + 1'b1;
                lnum_reg <= numy_reg;
                lmag_reg <= ady_reg;
                numy_reg <= numy_reg + NUM_W'(tpix);
                side_reg <= 1'b1;
            end
        end
        if (cmd.test && cell_hit)
        begin
            hit_reg  <= 1'b1;
            wall_reg <= rd_reg;
        end
        if (cmd.lat_dist)
            dist_reg <= div_q;
        // Hit point offsets: |dir| * distance in two partial products per axis.
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
            if (cmd.mul_step == MS_XHI || cmd.mul_step == MS_YHI)
                acclo_reg <= prod_reg;
            if (cmd.mul_step == MS_YLO)
                offx_reg <= ACC_W'(acclo_reg) + (ACC_W'(prod_reg) << LO_W);
            if (cmd.mul_step == MS_LAST)
                offy_reg <= ACC_W'(acclo_reg) + (ACC_W'(prod_reg) << LO_W);
        end
    end

    // Result register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.out_load)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    // Result register: payload.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            ohit_reg  <= hit_reg;
            owall_reg <= wall_reg;
            oside_reg <= side_reg;
            ohd_reg   <= (inf || hd > HD_W'(POS_MAX)) ? POS_MAX : hd[POS_W-1:0];
            if (!stepped_reg)
                operp_reg <= '0;
            else if (inf || dist_reg > DIVD_W'(POS_MAX))
                operp_reg <= POS_MAX;
            else
                operp_reg <= dist_reg[POS_W-1:0];
            ohx_reg <= sat_coord(ox_reg, xneg_reg, offx_reg[ACC_W-1:DIR_FRAC]);
            ohy_reg <= sat_coord(oy_reg, yneg_reg, offy_reg[ACC_W-1:DIR_FRAC]);
        end
    end

    assign sts.div_busy   = div_busy;
    assign sts.depth_zero = (depth_reg == '0);
    assign sts.stop       = cell_hit || dstop;
    assign sts.out_free   = out_free;

    assign out_valid         = ovalid_reg;
    assign out_hit_found     = ohit_reg;
    assign out_wall_type     = owall_reg;
    assign out_hit_distance  = ohd_reg;
    assign out_perp_distance = operp_reg;
    assign out_hit_x         = ohx_reg;
    assign out_hit_y         = ohy_reg;
    assign out_side          = oside_reg;

endmodule

`default_nettype wire

[hw/rtl/dgrc_ctrl.sv]
// Controller of the ray caster: sequences divisions, grid steps and the result.
`default_nettype none
`include "assert_macros.svh"

module dgrc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_op,
    output logic                      in_ready,
    input  wire dgrc_pkg::dgrc_sts_t  sts,
    output dgrc_pkg::dgrc_cmd_t       cmd
);
    import dgrc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DXS  = 4'd1;
    localparam logic [3:0] S_DXW  = 4'd2;
    localparam logic [3:0] S_DYS  = 4'd3;
    localparam logic [3:0] S_DYW  = 4'd4;
    localparam logic [3:0] S_INIT = 4'd5;
    localparam logic [3:0] S_STEP = 4'd6;
    localparam logic [3:0] S_READ = 4'd7;
    localparam logic [3:0] S_TEST = 4'd8;
    localparam logic [3:0] S_FDS  = 4'd9;
    localparam logic [3:0] S_FDW  = 4'd10;
    localparam logic [3:0] S_MUL  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [2:0] mul_cnt_reg, mul_cnt_next;

    // Next state and commands.
    always_comb
    begin
        state_next   = state_reg;
        mul_cnt_next = '0;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid && (in_op == OP_CAST);
                cmd.write   = in_valid && (in_op == OP_WRITE);
                if (in_valid && (in_op == OP_CAST))
                    state_next = S_DXS;
            end
            S_DXS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_TX;
                state_next    = S_DXW;
            end
            S_DXW:
            begin
                cmd.div_sel = DSEL_TX;
                if (!sts.div_busy)
                begin
                    cmd.lat_x  = 1'b1;
                    state_next = S_DYS;
                end
            end
            S_DYS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_TY;
                state_next    = S_DYW;
            end
            S_DYW:
            begin
                cmd.div_sel = DSEL_TY;
                if (!sts.div_busy)
                begin
                    cmd.lat_y  = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = sts.depth_zero ? S_MUL : S_STEP;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                cmd.test   = 1'b1;
                state_next = sts.stop ? S_FDS : S_STEP;
            end
            S_FDS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DSEL_DIST;
                state_next    = S_FDW;
            end
            S_FDW:
            begin
                cmd.div_sel = DSEL_DIST;
                if (!sts.div_busy)
                begin
                    cmd.lat_dist = 1'b1;
                    state_next   = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_step = mul_cnt_reg;
                if (mul_cnt_reg == MS_LAST)
                    state_next = S_OUT;
                else
                    mul_cnt_next = mul_cnt_reg + 1'b1;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mul_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mul_cnt_reg <= mul_cnt_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    `DGRC_ASSERT(a_idle_div_free, (state_reg == S_IDLE) |-> !sts.div_busy, "divider busy in idle")
    `DGRC_ASSERT(a_div_starts, (state_reg == S_DXS) |=> sts.div_busy, "divider did not start")
    `DGRC_ASSERT(a_mul_range, (state_reg == S_MUL) |-> (mul_cnt_reg <= MS_LAST), "multiply count overrun")
    `DGRC_NEVER(a_load_full, cmd.out_load && !sts.out_free, "result register overwritten")

endmodule

`default_nettype wire

[hw/rtl/dda_grid_ray_cast_unit.sv]
// Top level of the grid ray caster: controller, datapath and channel ports.
//
// The unit holds a tile map (MAP_W_MAX x MAP_H_MAX cells of 8 bits) and walks
// a 2D grid with DDA stepping. A write word stores one cell. An accepted cast
// word runs three divisions on one shared iterative divider (tile index of x,
// tile index of y, final crossing distance), each a start state and a wait state.
// The first two are followed by a setup state and the grid steps (step choice,
// map read, cell test), the last by the hit point multiplies and the result load.
// With a zero depth the steps and the last division are skipped. Only one word
// is in work at a time; the result register lets the next word in while a
// result waits. The map has no reset and no clearing pass: write a cell before
// a ray can reach it.
`default_nettype none

module dda_grid_ray_cast_unit #(
    parameter int MAP_W_MAX = 64,
    parameter int MAP_H_MAX = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    dgrc_in_if.sink                             req,
    dgrc_out_if.source                          rsp,
    input  wire logic                           cfg_we,
    input  wire logic [dgrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [dgrc_pkg::POS_W-1:0]     cfg_data
);
    import dgrc_pkg::*;

    dgrc_cmd_t cmd;
    dgrc_sts_t sts;
    logic      in_ready;

    dgrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.op),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dgrc_dpath #(
        .MAP_W_MAX (MAP_W_MAX),
        .MAP_H_MAX (MAP_H_MAX)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_cell_x         (req.cell_x),
        .in_cell_y         (req.cell_y),
        .in_cell_value     (req.cell_value),
        .in_origin_x       (req.origin_x),
        .in_origin_y       (req.origin_y),
        .in_dir_x          (req.dir_x),
        .in_dir_y          (req.dir_y),
        .out_ready         (rsp.ready),
        .out_valid         (rsp.valid),
        .out_hit_found     (rsp.hit_found),
        .out_wall_type     (rsp.wall_type),
        .out_hit_distance  (rsp.hit_distance),
        .out_perp_distance (rsp.perp_distance),
        .out_hit_x         (rsp.hit_x),
        .out_hit_y         (rsp.hit_y),
        .out_side          (rsp.side)
    );

    assign req.ready = in_ready;

endmodule

`default_nettype wire

[dv/dda_grid_ray_cast_unit_test.sv]
// Self-checking testbench of the grid ray caster: map writes, ray casts and register phases.
`default_nettype none

module dda_grid_ray_cast_unit_test;
    import dgrc_pkg::*;

    localparam int  MAP_COLS    = 64;
    localparam int  MAP_ROWS    = 64;
    localparam int  CLEAR_N     = 24;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE_CYC  = 16;
    localparam int  TAIL_CYC    = 200;
    localparam int  RAND_PHASES = 10;
    localparam int  PHASE_WORDS = 50;
    localparam longint unsigned DIST_INF = 64'd1 << 40;
    localparam longint unsigned DIST_BIAS = ((7 << FRAC_BITS) + 50) / 100;

    // One input word and one result word.
    typedef struct {
        logic                    op;
        logic [CXY_W-1:0]        cell_x;
        logic [CXY_W-1:0]        cell_y;
        logic [VAL_W-1:0]        cell_value;
        logic [POS_W-1:0]        origin_x;
        logic [POS_W-1:0]        origin_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
    } ray_word_t;

    typedef struct {
        logic                    hit_found;
        logic [VAL_W-1:0]        wall_type;
        logic [POS_W-1:0]        hit_distance;
        logic [POS_W-1:0]        perp_distance;
        logic signed [HIT_W-1:0] hit_x;
        logic signed [HIT_W-1:0] hit_y;
        logic                    side;
    } ray_result_t;

    // One row of the directed table: a register write or a word.
    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [POS_W-1:0]     reg_value;
        ray_word_t            w;
        bit                   typed;
        ray_result_t          r;
    } vector_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [POS_W-1:0] cfg_data;

    dgrc_in_if  req_if ();
    dgrc_out_if rsp_if ();

    dda_grid_ray_cast_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the map and of the registers.
    bit [VAL_W-1:0]  tile_map [MAP_COLS*MAP_ROWS];
    logic [TILE_W-1:0] reg_tile;
    logic [DIM_W-1:0]  reg_width;
    logic [DIM_W-1:0]  reg_height;
    logic [POS_W-1:0]  reg_depth;

    ray_result_t pending_hits[$];
    vector_t     directed[$];
    int  errors;
    int  casts_done;
    int  hits_seen;
    int  writes_done;
    int  cycles;
    bit  calm;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic longint unsigned crossing(longint unsigned num, longint unsigned mag);
        longint unsigned v;
        if (mag == 0)
            return DIST_INF;
        v = (num << DIR_FRAC) / mag;
        return (v > DIST_INF) ? DIST_INF : v;
    endfunction

    function automatic logic signed [HIT_W-1:0] hit_point(longint unsigned org, longint dir,
                                                          longint unsigned travel);
        longint unsigned mag;
        longint off;
        longint p;
        mag = (dir < 0) ? -dir : dir;
        off = longint'((mag * travel) >> DIR_FRAC);
        p = longint'(org) + ((dir < 0) ? -off : off);
        if (p > 2097151)
            p = 2097151;
        if (p < -2097152)
            p = -2097152;
        return p[HIT_W-1:0];
    endfunction

    // Walks the grid the way the block does and returns its result word.
    function automatic ray_result_t trace_ray(ray_word_t w);
        longint unsigned tile, tpix, mw, mh, adx, ady, numx, numy, travel, hd;
        longint cx, cy, dx, dy;
        bit hit, stepped, takex;
        ray_result_t r;
        hit = 0;
        stepped = 0;
        r.side = 0;
        r.wall_type = '0;
        tile = (reg_tile == 0) ? 1 : ((reg_tile > 256) ? 256 : reg_tile);
        mw = (reg_width > MAP_COLS) ? MAP_COLS : reg_width;
        mh = (reg_height > MAP_ROWS) ? MAP_ROWS : reg_height;
        tpix = tile << FRAC_BITS;
        dx = w.dir_x;
        dy = w.dir_y;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        cx = longint'(w.origin_x / tpix);
        cy = longint'(w.origin_y / tpix);
        numx = w.origin_x - longint'(cx) * tpix;
        numy = w.origin_y - longint'(cy) * tpix;
        if (dx >= 0)
            numx = tpix - numx;
        if (dy >= 0)
            numy = tpix - numy;
        travel = 0;
        while (!hit && travel < reg_depth)
        begin
            if (adx == 0)
                takex = 0;
            else if (ady == 0)
                takex = 1;
            else
                takex = (numx * ady) < (numy * adx);
            if (takex)
            begin
                cx += (dx < 0) ? -1 : 1;
                travel = crossing(numx, adx);
                numx += tpix;
                r.side = 0;
            end
            else
            begin
                cy += (dy < 0) ? -1 : 1;
                travel = crossing(numy, ady);
                numy += tpix;
                r.side = 1;
            end
            stepped = 1;
            if (cx >= 0 && cx < mw && cy >= 0 && cy < mh)
            begin
                if (tile_map[cy * MAP_COLS + cx] != 0)
                begin
                    hit = 1;
                    r.wall_type = tile_map[cy * MAP_COLS + cx];
                end
            end
        end
        hd = travel + DIST_BIAS;
        r.hit_found = hit;
        r.hit_distance = (hd > POS_MAX) ? POS_MAX : hd[POS_W-1:0];
        r.perp_distance = !stepped ? '0 : ((travel > POS_MAX) ? POS_MAX : travel[POS_W-1:0]);
        r.hit_x = hit_point(w.origin_x, dx, hd);
        r.hit_y = hit_point(w.origin_y, dy, hd);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("[%0d] mismatch on %s: got %0d, expected %0d", cycles, field, got, want);
    endtask

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // Register write, only while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [POS_W-1:0] value);
        // Take the last word off the channel so it is not accepted again.
        @(negedge clk);
        req_if.valid = 1'b0;
        wait (pending_hits.size() == 0);
        repeat (SETTLE_CYC) @(posedge clk);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_TILE_SIZE:  reg_tile = value[TILE_W-1:0];
            CFG_MAP_WIDTH:  reg_width = value[DIM_W-1:0];
            CFG_MAP_HEIGHT: reg_height = value[DIM_W-1:0];
            default:        reg_depth = value;
        endcase
    endtask

    // Presents one word and records what it should cause once it is taken.
    task automatic send_word(ray_word_t w, bit typed, ray_result_t want);
        int gap;
        gap = draw_gap();
        repeat (gap)
        begin
            @(negedge clk);
            req_if.valid = 1'b0;
        end
        @(negedge clk);
        req_if.valid = 1'b1;
        req_if.op = w.op;
        req_if.cell_x = w.cell_x;
        req_if.cell_y = w.cell_y;
        req_if.cell_value = w.cell_value;
        req_if.origin_x = w.origin_x;
        req_if.origin_y = w.origin_y;
        req_if.dir_x = w.dir_x;
        req_if.dir_y = w.dir_y;
        do
            @(posedge clk);
        while (!req_if.ready);
        if (w.op == OP_CAST)
        begin
            pending_hits.push_back(typed ? want : trace_ray(w));
            casts_done++;
        end
        else
        begin
            tile_map[w.cell_y * MAP_COLS + w.cell_x] = w.cell_value;
            writes_done++;
        end
    endtask

    function automatic ray_word_t map_write(int x, int y, int value);
        ray_word_t w;
        w = '{default: '0};
        w.op = OP_WRITE;
        w.cell_x = CXY_W'(x);
        w.cell_y = CXY_W'(y);
        w.cell_value = VAL_W'(value);
        return w;
    endfunction

    function automatic ray_word_t ray(int ox, int oy, int dx, int dy);
        ray_word_t w;
        w = '{default: '0};
        w.op = OP_CAST;
        w.origin_x = POS_W'(ox);
        w.origin_y = POS_W'(oy);
        w.dir_x = DIR_W'(dx);
        w.dir_y = DIR_W'(dy);
        return w;
    endfunction

    function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, int value);
        vector_t v;
        v = '{default: '0};
        v.is_reg = 1;
        v.reg_index = idx;
        v.reg_value = POS_W'(value);
        directed.push_back(v);
    endfunction

    function automatic void add_word(ray_word_t w);
        vector_t v;
        v = '{default: '0};
        v.w = w;
        directed.push_back(v);
    endfunction

    function automatic void add_typed(ray_word_t w, ray_result_t r);
        vector_t v;
        v = '{default: '0};
        v.w = w;
        v.typed = 1;
        v.r = r;
        directed.push_back(v);
    endfunction

    // Random cast, mostly starting inside the map in use.
    function automatic ray_word_t random_ray();
        longint unsigned span_x, span_y, tile;
        int dx, dy;
        tile = (reg_tile == 0) ? 1 : ((reg_tile > 256) ? 256 : reg_tile);
        span_x = ((reg_width == 0) ? 64 : reg_width) * tile * 256;
        span_y = ((reg_height == 0) ? 64 : reg_height) * tile * 256;
        if (span_x > 1048576)
            span_x = 1048576;
        if (span_y > 1048576)
            span_y = 1048576;
        dx = $urandom_range(0, 32768) - 16384;
        dy = $urandom_range(0, 32768) - 16384;
        case ($urandom_range(0, 9))
            0: dx = 0;
            1: dy = 0;
            2: dx = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
            3: dy = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
            default: ;
        endcase
        if ($urandom_range(0, 9) == 0)
            return ray($urandom_range(0, 1048575), $urandom_range(0, 1048575), dx, dy);
        return ray($urandom_range(0, span_x - 1), $urandom_range(0, span_y - 1), dx, dy);
    endfunction

    // Random register setting that keeps the walk at a sane number of steps.
    // Map dimensions stay within the cleared corner of the map.
    task automatic random_setting(int phase);
        int tile;
        int depth_cap;
        case ($urandom_range(0, 5))
            0: tile = 1;
            1: tile = 256;
            2: tile = ($urandom_range(0, 1) != 0) ? 0 : 511;
            default: tile = $urandom_range(8, 256);
        endcase
        write_reg(CFG_TILE_SIZE, POS_W'(tile));
        write_reg(CFG_MAP_WIDTH, POS_W'(($urandom_range(0, 7) == 0) ? 0
                                        : $urandom_range(1, CLEAR_N)));
        write_reg(CFG_MAP_HEIGHT, POS_W'(($urandom_range(0, 7) == 0) ? 0
                                         : $urandom_range(1, CLEAR_N)));
        depth_cap = ((tile == 0) ? 1 : ((tile > 256) ? 256 : tile)) * 256 * 40;
        if (depth_cap > 1048575)
            depth_cap = 1048575;
        if (phase == 1)
            write_reg(CFG_MAX_DEPTH, '0);
        else if (phase == 2)
            write_reg(CFG_MAX_DEPTH, POS_W'(depth_cap));
        else
            write_reg(CFG_MAX_DEPTH, POS_W'($urandom_range(0, depth_cap)));
    endtask

    // Stimulus.
    initial
    begin
        ray_result_t idle_hit;
        ray_result_t no_want;
        ray_word_t   w;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_TILE_SIZE;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.op = OP_WRITE;
        req_if.cell_x = '0;
        req_if.cell_y = '0;
        req_if.cell_value = '0;
        req_if.origin_x = '0;
        req_if.origin_y = '0;
        req_if.dir_x = '0;
        req_if.dir_y = '0;
        reg_tile = TILE_RST;
        reg_width = DIM_RST;
        reg_height = DIM_RST;
        reg_depth = DEPTH_RST;
        errors = 0;
        casts_done = 0;
        hits_seen = 0;
        writes_done = 0;
        no_want = '{default: '0};
        calm = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The map has no reset, so the corner that rays can reach is cleared first.
        for (int y = 0; y < CLEAR_N; y++)
            for (int x = 0; x < CLEAR_N; x++)
                send_word(map_write(x, y, 0), 0, no_want);
        calm = 0;

        // Zero depth with a zero direction: no step, only the bias.
        add_reg(CFG_MAX_DEPTH, 0);
        idle_hit = '{1'b0, 8'd0, 20'd18, 20'd0, 22'sd100, 22'sd200, 1'b0};
        add_typed(ray(100, 200, 0, 0), idle_hit);
        add_reg(CFG_MAX_DEPTH, DEPTH_RST);
        // Both components zero: one y step at infinite distance, saturated.
        idle_hit = '{1'b0, 8'd0, 20'hFFFFF, 20'hFFFFF, 22'sh28000, 22'sh28000, 1'b1};
        add_typed(ray('h28000, 'h28000, 0, 0), idle_hit);
        add_word(map_write(5, 3, 7));
        add_word(map_write(0, 0, 1));
        add_word(map_write(63, 63, 255));
        add_word(map_write(42, 21, 170));
        add_word(ray('h4000 + 77, 'hC000 + 9000, 16384, 0));
        add_word(ray('h6123, 'h5F00, -16384, -16384));
        // Far corner rays run outside a map shrunk to the cleared corner.
        add_reg(CFG_MAP_WIDTH, CLEAR_N);
        add_reg(CFG_MAP_HEIGHT, CLEAR_N);
        add_word(ray('hF7F00, 'hF7F00, 16384, 16384));
        add_word(ray('h7FFFF, 'h55555, -16384, 16384));
        add_word(ray('hFFFFF, 'hFFFFF, 16384, -16384));
        add_word(ray(0, 0, 1, -1));
        add_reg(CFG_TILE_SIZE, 0);
        add_reg(CFG_MAP_WIDTH, 0);
        add_word(ray(300, 300, 12000, -9000));
        add_reg(CFG_TILE_SIZE, 511);
        add_reg(CFG_MAP_WIDTH, 127);
        add_reg(CFG_MAP_HEIGHT, 127);
        add_reg(CFG_MAX_DEPTH, 'hFFFFF);
        add_word(ray('h2AAAA, 'h15555, 9000, 12000));
        add_reg(CFG_TILE_SIZE, 1);
        add_reg(CFG_MAP_WIDTH, CLEAR_N);
        add_reg(CFG_MAP_HEIGHT, 1);
        add_word(ray(128, 100, 16384, 1));
        add_word(ray(16000, 100, -16384, 3));

        foreach (directed[i])
        begin
            if (directed[i].is_reg)
                write_reg(directed[i].reg_index, directed[i].reg_value);
            else
                send_word(directed[i].w, directed[i].typed, directed[i].r);
        end

        // Random phases: a fresh setting, then a mix of writes and casts.
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            random_setting(phase);
            calm = (phase % 4 == 3);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if ($urandom_range(0, 9) < 3)
                begin
                    w = map_write($urandom_range(0, CLEAR_N - 1), $urandom_range(0, CLEAR_N - 1),
                                  ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 255));
                    send_word(w, 0, no_want);
                end
                else
                    send_word(random_ray(), 0, no_want);
            end
            calm = 0;
        end

        @(negedge clk);
        req_if.valid = 1'b0;
        wait (pending_hits.size() == 0);
        repeat (TAIL_CYC) @(posedge clk);
        $display("Ran %0d casts (%0d hits) and %0d map writes over %0d register settings.",
                 casts_done, hits_seen, writes_done, RAND_PHASES + 4);
        if (errors == 0)
            $display("Regression PASS");
        else
        begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end

    // Result side: random stalls, then checks each word taken.
    initial
    begin
        int stall;
        ray_result_t want;
        rsp_if.ready = 1'b0;
        forever
        begin
            stall = draw_gap();
            repeat (stall)
            begin
                @(negedge clk);
                rsp_if.ready = 1'b0;
            end
            @(negedge clk);
            rsp_if.ready = 1'b1;
            do
                @(posedge clk);
            while (!(rsp_if.valid === 1'b1));
            if (pending_hits.size() == 0)
                report_mismatch("result word with no cast waiting", 1, 0);
            else
            begin
                want = pending_hits.pop_front();
                if (rsp_if.hit_found === 1'b1)
                    hits_seen++;
                if (rsp_if.hit_found !== want.hit_found)
                    report_mismatch("hit_found", rsp_if.hit_found, want.hit_found);
                if (rsp_if.wall_type !== want.wall_type)
                    report_mismatch("wall_type", rsp_if.wall_type, want.wall_type);
                if (rsp_if.hit_distance !== want.hit_distance)
                    report_mismatch("hit_distance", rsp_if.hit_distance, want.hit_distance);
                if (rsp_if.perp_distance !== want.perp_distance)
                    report_mismatch("perp_distance", rsp_if.perp_distance, want.perp_distance);
                if (rsp_if.hit_x !== want.hit_x)
                    report_mismatch("hit_x", rsp_if.hit_x, want.hit_x);
                if (rsp_if.hit_y !== want.hit_y)
                    report_mismatch("hit_y", rsp_if.hit_y, want.hit_y);
                if (rsp_if.side !== want.side)
                    report_mismatch("side", rsp_if.side, want.side);
            end
        end
    end

endmodule

`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/dgrc_pkg.sv
hw/rtl/dgrc_in_if.sv
hw/rtl/dgrc_out_if.sv
hw/rtl/dgrc_div.sv
hw/rtl/dgrc_dpath.sv
hw/rtl/dgrc_ctrl.sv
hw/rtl/dda_grid_ray_cast_unit.sv
dv/dda_grid_ray_cast_unit_test.sv
